### src/hex_record_parser_assert.svh
// Assertion macros shared by the checker of the hex record parser.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef HEX_RECORD_PARSER_ASSERT_SVH
`define HEX_RECORD_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HRP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hex_record_parser: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HRP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hex_record_parser: assertion failed");

`endif

### src/hrp_pkg.sv
// Package of the hex record parser: token and result types, status codes.
// Used by hrp_front, hrp_back, hex_record_parser and hrp_checker; depends on nothing.
package hrp_pkg;

    typedef enum logic [2:0] {
        TK_HEX   = 3'd0,
        TK_BLANK = 3'd1,
        TK_NL    = 3'd2,
        TK_COLON = 3'd3,
        TK_OTHER = 3'd4
    } tok_class_t;

    typedef struct packed {
        tok_class_t cls;
        logic [3:0] nib;
    } token_t;

    localparam logic       KIND_BYTE = 1'b0;
    localparam logic       KIND_STAT = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_CSUM = 2'd1;
    localparam logic [1:0] ST_FMT  = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [7:0]  value;
        logic [8:0]  pos;
        logic [1:0]  status;
        logic [7:0]  len;
        logic [15:0] sum;
    } result_t;

endpackage

### src/hrp_front.sv
// Front part of the hex record parser: classifies each character and queues the token.
// Depends on hrp_pkg.
module hrp_front
    import hrp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] ch,
    output logic       tok_valid,
    output token_t     tok,
    input  logic       tok_pop
);

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF_NL = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;

    token_t      class_tok;
    token_t      mem_reg [4];
    logic [1:0]  wr_ptr_reg;
    logic [1:0]  wr_ptr_next;
    logic [1:0]  rd_ptr_reg;
    logic [1:0]  rd_ptr_next;
    logic [2:0]  cnt_reg;
    logic [2:0]  cnt_next;
    logic        wr_en;
    logic [7:0]  diff;

    always_comb
    begin
        class_tok.cls = TK_OTHER;
        class_tok.nib = 4'd0;
        diff          = 8'd0;
        if (ch >= CH_0 && ch <= CH_9)
        begin
            diff          = ch - CH_0;
            class_tok.cls = TK_HEX;
            class_tok.nib = diff[3:0];
        end
        else if (ch >= CH_UA && ch <= CH_UF)
        begin
            diff          = ch - CH_UA + 8'd10;
            class_tok.cls = TK_HEX;
            class_tok.nib = diff[3:0];
        end
        else if (ch >= CH_LA && ch <= CH_LF)
        begin
            diff          = ch - CH_LA + 8'd10;
            class_tok.cls = TK_HEX;
            class_tok.nib = diff[3:0];
        end
        else if (ch == CH_SPACE || ch == CH_CR)
        begin
            class_tok.cls = TK_BLANK;
        end
        else if (ch == CH_LF_NL)
        begin
            class_tok.cls = TK_NL;
        end
        else if (ch == CH_COLON)
        begin
            class_tok.cls = TK_COLON;
        end
    end

    assign full      = (cnt_reg == 3'd4);
    assign wr_en     = push && !full;
    assign tok_valid = (cnt_reg != 3'd0);
    assign tok       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = wr_ptr_reg + 2'd1;
        end
        if (tok_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 2'd1;
        end
        if (wr_en && !tok_pop)
        begin
            cnt_next = cnt_reg + 3'd1;
        end
        else if (!wr_en && tok_pop)
        begin
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            cnt_reg    <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= class_tok;
        end
    end

endmodule

### src/hrp_back.sv
// Back part of the hex record parser: record state machine, sums and result queue.
// Depends on hrp_pkg.
module hrp_back
    import hrp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    tok_valid,
    input  token_t  tok,
    output logic    tok_pop,
    output logic    res_empty,
    output result_t res,
    input  logic    res_pop
);

    typedef enum logic [2:0] {
        PH_WAIT = 3'b001,
        PH_REC  = 3'b010,
        PH_SKIP = 3'b100
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [3:0]  high_reg;
    logic [3:0]  high_next;
    logic        have_reg;
    logic        have_next;
    logic [8:0]  idx_reg;
    logic [8:0]  idx_next;
    logic [7:0]  count_reg;
    logic [7:0]  count_next;
    logic [7:0]  sum_reg;
    logic [7:0]  sum_next;
    logic [15:0] image_reg;
    logic [15:0] image_next;

    logic        emit;
    result_t     new_res;
    logic [7:0]  byte_val;
    logic [8:0]  last_idx;

    result_t     mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        room;
    logic        res_pull;

    assign room      = (cnt_reg != 2'd2);
    assign tok_pop   = tok_valid && room;
    assign res_empty = (cnt_reg == 2'd0);
    assign res       = mem_reg[rd_ptr_reg];
    assign res_pull  = res_pop && !res_empty;
    assign byte_val  = {high_reg, tok.nib};
    assign last_idx  = {1'b0, count_reg} + 9'd3;

    always_comb
    begin
        phase_next     = phase_reg;
        high_next      = high_reg;
        have_next      = have_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        image_next     = image_reg;
        emit           = 1'b0;
        new_res.kind   = KIND_STAT;
        new_res.value  = 8'd0;
        new_res.pos    = 9'd0;
        new_res.status = ST_OK;
        if (tok_pop)
        begin
            case (phase_reg)
                PH_SKIP:
                begin
                    if (tok.cls == TK_NL)
                    begin
                        phase_next = PH_WAIT;
                    end
                end
                PH_REC:
                begin
                    case (tok.cls)
                        TK_BLANK:
                        begin
                        end
                        TK_NL:
                        begin
                            phase_next     = PH_WAIT;
                            emit           = 1'b1;
                            new_res.status = ST_FMT;
                        end
                        TK_HEX:
                        begin
                            if (!have_reg)
                            begin
                                high_next = tok.nib;
                                have_next = 1'b1;
                            end
                            else
                            begin
                                have_next = 1'b0;
                                if (idx_reg == 9'd0)
                                begin
                                    count_next = byte_val;
                                    sum_next   = byte_val;
                                    idx_next   = 9'd1;
                                end
                                else if (idx_reg <= last_idx)
                                begin
                                    sum_next      = sum_reg + byte_val;
                                    image_next    = image_reg
                                                  + {{8{byte_val[7]}}, byte_val};
                                    idx_next      = idx_reg + 9'd1;
                                    emit          = 1'b1;
                                    new_res.kind  = KIND_BYTE;
                                    new_res.value = byte_val;
                                    new_res.pos   = idx_reg - 9'd1;
                                end
                                else
                                begin
                                    phase_next     = PH_SKIP;
                                    emit           = 1'b1;
                                    new_res.status = (byte_val == (8'd0 - sum_reg))
                                                   ? ST_OK : ST_CSUM;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next     = PH_SKIP;
                            emit           = 1'b1;
                            new_res.status = ST_FMT;
                        end
                    endcase
                end
                default:
                begin
                    if (tok.cls == TK_COLON)
                    begin
                        phase_next = PH_REC;
                        high_next  = 4'd0;
                        have_next  = 1'b0;
                        idx_next   = 9'd0;
                        count_next = 8'd0;
                        sum_next   = 8'd0;
                    end
                    else
                    begin
                        phase_next = PH_WAIT;
                    end
                end
            endcase
        end
        new_res.len = count_next;
        new_res.sum = image_next;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (emit && !res_pull)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!emit && res_pull)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_WAIT;
            high_reg   <= 4'd0;
            have_reg   <= 1'b0;
            idx_reg    <= 9'd0;
            count_reg  <= 8'd0;
            sum_reg    <= 8'd0;
            image_reg  <= 16'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            high_reg   <= high_next;
            have_reg   <= have_next;
            idx_reg    <= idx_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            image_reg  <= image_next;
            wr_ptr_reg <= wr_ptr_reg ^ emit;
            rd_ptr_reg <= rd_ptr_reg ^ res_pull;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            mem_reg[wr_ptr_reg] <= new_res;
        end
    end

endmodule

### src/hex_record_parser.sv
// Channel  | Handshake    | Payload
// input    | push, full   | ch
// result   | empty, pop   | kind, byte_value, byte_position, status, record_length, image_sum
//
// One character is taken every cycle while full is low; tokens and results are registered.
// The record state machine sets the rate: a token per cycle while the result queue has room.
// Reset clears both queues and the parser, which then waits for a colon.
// A stalled result side fills the two-entry result queue, then the four-entry token queue,
// and only then raises full.
// Top level of the hex record parser; depends on hrp_pkg, hrp_front and hrp_back.
module hex_record_parser
    import hrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  ch,
    output logic        empty,
    input  logic        pop,
    output logic        kind,
    output logic [7:0]  byte_value,
    output logic [8:0]  byte_position,
    output logic [1:0]  status,
    output logic [7:0]  record_length,
    output logic [15:0] image_sum
);

    logic    tok_valid;
    token_t  tok;
    logic    tok_pop;
    result_t res;

    hrp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .ch        (ch),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_pop   (tok_pop)
    );

    hrp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_pop   (tok_pop),
        .res_empty (empty),
        .res       (res),
        .res_pop   (pop)
    );

    assign kind          = res.kind;
    assign byte_value    = res.value;
    assign byte_position = res.pos;
    assign status        = res.status;
    assign record_length = res.len;
    assign image_sum     = res.sum;

endmodule

### src/hrp_checker.sv
// Port checker of the hex record parser and the bind that attaches it.
// Depends on hrp_pkg and hex_record_parser_assert.svh.
`include "hex_record_parser_assert.svh"

module hrp_checker
    import hrp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic        kind,
    input logic [7:0]  byte_value,
    input logic [8:0]  byte_position,
    input logic [1:0]  status,
    input logic [7:0]  record_length,
    input logic [15:0] image_sum
);

    logic [43:0] res_bits;
    logic [8:0]  pos_limit;
    logic        byte_clean;
    logic        stat_clean;

    assign res_bits   = {kind, byte_value, byte_position, status, record_length, image_sum};
    assign pos_limit  = {1'b0, record_length} + 9'd2;
    assign byte_clean = (byte_position <= pos_limit) && (status == ST_OK);
    assign stat_clean = (byte_value == 8'd0) && (byte_position == 9'd0) && (status <= ST_FMT);

    `HRP_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(res_bits))
    `HRP_ASSERT_NOW(a_pos_in_record, !empty && kind == KIND_BYTE, byte_clean)
    `HRP_ASSERT_NOW(a_status_clean, !empty && kind == KIND_STAT, stat_clean)
    `HRP_ASSERT_NOW(a_queues_after_reset, $rose(rst_n), empty && !full)

endmodule

bind hex_record_parser hrp_checker u_hrp_checker (.*);
